// ----- design/skt_pkg.sv -----
// Package for the sorted key table: payload structs, operation and state codes,
// and default sizes. No dependencies.
package skt_pkg;

  localparam int unsigned DEPTH_DEF = 64;
  localparam int unsigned KEY_W     = 32;
  localparam int unsigned POS_W     = 6;
  localparam int unsigned CAP_W     = 7;
  localparam logic [CAP_W-1:0] CAP_RESET = 7'd64;

  typedef enum logic [1:0] {
    MODE_INSERT = 2'd0,
    MODE_GET    = 2'd1,
    MODE_REMOVE = 2'd2
  } mode_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_INS_STEP,
    ST_INS_LAST,
    ST_GET,
    ST_REM_FIRST,
    ST_REM_STEP
  } state_e;

  typedef struct packed {
    mode_e             mode;
    logic [KEY_W-1:0]  key_value;
    logic [POS_W-1:0]  position;
  } cmd_t;

  typedef struct packed {
    logic              ok;
    logic [KEY_W-1:0]  read_value;
    logic [CAP_W-1:0]  fill_count;
  } rsp_t;

endpackage

// ----- design/skt_ram.sv -----
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
module skt_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ----- design/skt_engine.sv -----
// Sequencer and key compare unit that walk the key RAM for insert, get and remove.
// Depends on skt_pkg and skt_ram.
module skt_engine import skt_pkg::*; #(
  parameter int unsigned DEPTH = DEPTH_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  input  cmd_t                         cmd_i,
  input  logic [$clog2(DEPTH+1)-1:0]   limit_i,
  output logic                         busy_o,
  output logic                         done_o,
  output rsp_t                         rsp_o
);

  localparam int unsigned AW = $clog2(DEPTH);
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam int unsigned PW = (CW > POS_W) ? CW : POS_W;

  state_e             state_q, state_d;
  logic [CW-1:0]      count_q, count_d;
  logic [CW-1:0]      j_q, j_d;
  logic [KEY_W-1:0]   key_q, key_d;
  logic [KEY_W-1:0]   gone_q, gone_d;
  logic               done_q, done_d;
  rsp_t               rsp_q, rsp_d;

  logic               mem_we;
  logic [AW-1:0]      mem_waddr;
  logic [KEY_W-1:0]   mem_wdata;
  logic [AW-1:0]      mem_raddr;
  logic [KEY_W-1:0]   mem_rdata;

  logic               accept;
  logic               room_ok;
  logic               pos_ok;
  logic               key_lt;
  logic [CW:0]        j_plus1;
  logic [CW:0]        j_plus2;
  logic               more1;
  logic               more2;

  assign accept  = start_i && (state_q == ST_IDLE);
  assign room_ok = count_q < limit_i;
  assign pos_ok  = PW'(cmd_i.position) < PW'(count_q);
  assign key_lt  = mem_rdata < key_q;
  assign j_plus1 = (CW+1)'(j_q) + (CW+1)'(1);
  assign j_plus2 = (CW+1)'(j_q) + (CW+1)'(2);
  assign more1   = j_plus1 < (CW+1)'(count_q);
  assign more2   = j_plus2 < (CW+1)'(count_q);

  skt_ram #(
    .Width (KEY_W),
    .Depth (DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          unique case (cmd_i.mode)
            MODE_INSERT: begin
              if (room_ok) begin
                state_d = (count_q == '0) ? ST_INS_LAST : ST_INS_STEP;
              end
            end
            MODE_GET: begin
              if (pos_ok) begin
                state_d = ST_GET;
              end
            end
            MODE_REMOVE: begin
              if (pos_ok) begin
                state_d = ST_REM_FIRST;
              end
            end
            default: state_d = ST_IDLE;
          endcase
        end
      end
      ST_INS_STEP: begin
        if (key_lt) begin
          state_d = ST_IDLE;
        end else if (j_q == CW'(1)) begin
          state_d = ST_INS_LAST;
        end
      end
      ST_INS_LAST:  state_d = ST_IDLE;
      ST_GET:       state_d = ST_IDLE;
      ST_REM_FIRST: state_d = more1 ? ST_REM_STEP : ST_IDLE;
      ST_REM_STEP:  state_d = more2 ? ST_REM_STEP : ST_IDLE;
      default:      state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = AW'(j_q);
    mem_wdata = mem_rdata;
    mem_raddr = AW'(j_q);
    j_d       = j_q;
    key_d     = key_q;
    gone_d    = gone_q;
    count_d   = count_q;
    done_d    = 1'b0;
    rsp_d     = rsp_q;
    unique case (state_q)
      ST_IDLE: begin
        key_d = cmd_i.key_value;
        if (cmd_i.mode == MODE_INSERT) begin
          mem_raddr = AW'(count_q - CW'(1));
          j_d       = count_q;
        end else begin
          mem_raddr = AW'(cmd_i.position);
          j_d       = CW'(cmd_i.position);
        end
        if (accept && !((cmd_i.mode == MODE_INSERT && room_ok) ||
                        (cmd_i.mode == MODE_GET && pos_ok) ||
                        (cmd_i.mode == MODE_REMOVE && pos_ok))) begin
          done_d = 1'b1;
          rsp_d  = '{ok: 1'b0, read_value: '0, fill_count: CAP_W'(count_q)};
        end
      end
      ST_INS_STEP: begin
        mem_raddr = AW'(j_q - CW'(2));
        mem_we    = 1'b1;
        if (key_lt) begin
          mem_wdata = key_q;
          count_d   = count_q + CW'(1);
          done_d    = 1'b1;
          rsp_d     = '{ok: 1'b1, read_value: '0, fill_count: CAP_W'(count_q + CW'(1))};
        end else begin
          j_d = j_q - CW'(1);
        end
      end
      ST_INS_LAST: begin
        mem_we    = 1'b1;
        mem_wdata = key_q;
        count_d   = count_q + CW'(1);
        done_d    = 1'b1;
        rsp_d     = '{ok: 1'b1, read_value: '0, fill_count: CAP_W'(count_q + CW'(1))};
      end
      ST_GET: begin
        done_d = 1'b1;
        rsp_d  = '{ok: 1'b1, read_value: mem_rdata, fill_count: CAP_W'(count_q)};
      end
      ST_REM_FIRST: begin
        gone_d    = mem_rdata;
        mem_raddr = AW'(j_plus1);
        if (!more1) begin
          count_d = count_q - CW'(1);
          done_d  = 1'b1;
          rsp_d   = '{ok: 1'b1, read_value: mem_rdata, fill_count: CAP_W'(count_q - CW'(1))};
        end
      end
      ST_REM_STEP: begin
        mem_we    = 1'b1;
        mem_raddr = AW'(j_plus2);
        j_d       = CW'(j_plus1);
        if (!more2) begin
          count_d = count_q - CW'(1);
          done_d  = 1'b1;
          rsp_d   = '{ok: 1'b1, read_value: gone_q, fill_count: CAP_W'(count_q - CW'(1))};
        end
      end
      default: begin
        mem_we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      count_q <= '0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      done_q  <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    j_q    <= j_d;
    key_q  <= key_d;
    gone_q <= gone_d;
    rsp_q  <= rsp_d;
  end

  assign busy_o = (state_q != ST_IDLE);
  assign done_o = done_q;
  assign rsp_o  = rsp_q;

  a_count_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(DEPTH))
    else $error("Stored key count exceeds the table depth.");

  a_count_moves_on_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (count_q != $past(count_q)) |-> done_q)
    else $error("Key count changed without a result transfer.");

  a_fail_keeps_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_q && !rsp_q.ok) |-> (count_q == $past(count_q)))
    else $error("A failed operation changed the key count.");

  a_done_has_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> $past(state_q != ST_IDLE || start_i))
    else $error("Result strobe without an accepted command.");

  a_idle_no_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_IDLE) |-> !mem_we)
    else $error("Key RAM written while the sequencer is idle.");

endmodule

// ----- design/sorted_key_table_core.sv -----
// Top level of the sorted key table: capacity register, limit logic and the sequencer.
// Depends on skt_pkg and skt_engine.
//
//   channel   direction  handshake                 payload
//   command   in         start & !busy             cmd_i (mode, key_value, position)
//   result    out        done_o, one cycle         rsp_o (ok, read_value, fill_count)
//   config    in         cfg_valid_i & cfg_ready_o cfg_data_i (capacity)
//
// An insert moves each key not below the new one up a slot, walking down from the top; a
// get reads one entry; a remove at index P moves each key above P down a slot; a rejected
// command is answered from idle. The single RAM read port is walked once per entry.
// After reset the table is empty and capacity is 64; the RAM contents are not cleared.
// The result strobe is high for one cycle and the receiver cannot stall it.
module sorted_key_table_core import skt_pkg::*; #(
  parameter int unsigned DEPTH = DEPTH_DEF
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start,
  output logic             busy,
  input  cmd_t             cmd_i,
  output logic             done_o,
  output rsp_t             rsp_o,
  input  logic             cfg_valid_i,
  output logic             cfg_ready_o,
  input  logic [CAP_W-1:0] cfg_data_i
);

  localparam int unsigned CW   = $clog2(DEPTH + 1);
  localparam int unsigned CMPW = (CW > CAP_W) ? CW : CAP_W;

  logic [CAP_W-1:0] cap_q;
  logic [CMPW-1:0]  cap_ext;
  logic [CMPW-1:0]  depth_ext;
  logic [CW-1:0]    limit;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q <= CAP_RESET;
    end else if (cfg_valid_i && cfg_ready_o) begin
      cap_q <= cfg_data_i;
    end
  end

  assign cfg_ready_o = 1'b1;
  assign cap_ext     = CMPW'(cap_q);
  assign depth_ext   = CMPW'(DEPTH);
  assign limit       = (cap_ext < depth_ext) ? CW'(cap_ext) : CW'(depth_ext);

  skt_engine #(
    .DEPTH (DEPTH)
  ) u_engine (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start),
    .cmd_i   (cmd_i),
    .limit_i (limit),
    .busy_o  (busy),
    .done_o  (done_o),
    .rsp_o   (rsp_o)
  );

endmodule

// ----- test/tb_top.sv -----
// Self-checking testbench for sorted_key_table_core: directed and random insert, get and
// remove commands under several capacity settings, checked against a scoreboard model.
// Depends on skt_pkg and the sorted_key_table_core RTL.
module tb_top;
  import skt_pkg::*;

  localparam int unsigned TABLE_DEPTH = DEPTH_DEF;
  localparam int unsigned DRAIN_CYCLES = TABLE_DEPTH + 8;
  localparam int unsigned MAX_GAP = 40;
  localparam int unsigned PHASE_ITEMS = 130;

  class skt_scoreboard;
    logic [KEY_W-1:0] keys [TABLE_DEPTH];
    int unsigned      fill;
    int unsigned      cap;
    rsp_t             pending_rsp [$];
    int unsigned      errors;

    function new();
      fill = 0;
      cap = CAP_RESET;
      errors = 0;
    endfunction

    function void set_capacity(logic [CAP_W-1:0] value);
      cap = value;
    endfunction

    function int unsigned outstanding();
      return pending_rsp.size();
    endfunction

    function rsp_t predict(cmd_t c);
      rsp_t        r;
      int unsigned lim;
      int unsigned slot;
      int unsigned j;
      r = '0;
      lim = (cap < TABLE_DEPTH) ? cap : TABLE_DEPTH;
      case (c.mode)
        MODE_INSERT: begin
          if (fill < lim) begin
            slot = 0;
            while (slot < fill && keys[slot] < c.key_value) slot++;
            for (j = fill; j > slot; j--) keys[j] = keys[j-1];
            keys[slot] = c.key_value;
            fill++;
            r.ok = 1'b1;
          end
        end
        MODE_GET: begin
          if (c.position < fill) begin
            r.ok = 1'b1;
            r.read_value = keys[c.position];
          end
        end
        MODE_REMOVE: begin
          if (c.position < fill) begin
            r.ok = 1'b1;
            r.read_value = keys[c.position];
            for (j = c.position; j + 1 < fill; j++) keys[j] = keys[j+1];
            fill--;
          end
        end
        default: begin
        end
      endcase
      r.fill_count = fill[CAP_W-1:0];
      return r;
    endfunction

    function void note_cmd(cmd_t c);
      pending_rsp.push_back(predict(c));
    endfunction

    function void check_rsp(rsp_t got);
      rsp_t want;
      if (pending_rsp.size() == 0) begin
        $error("result with no command outstanding: ok=%0b read_value=%h fill_count=%0d",
               got.ok, got.read_value, got.fill_count);
        errors++;
        return;
      end
      want = pending_rsp.pop_front();
      if (got.ok !== want.ok) begin
        $error("ok: expected %0b, actual %0b", want.ok, got.ok);
        errors++;
      end
      if (got.read_value !== want.read_value) begin
        $error("read_value: expected %h, actual %h", want.read_value, got.read_value);
        errors++;
      end
      if (got.fill_count !== want.fill_count) begin
        $error("fill_count: expected %0d, actual %0d", want.fill_count, got.fill_count);
        errors++;
      end
    endfunction
  endclass

  logic             clk_i = 1'b0;
  logic             rst_ni = 1'b0;
  logic             start = 1'b0;
  logic             busy;
  cmd_t             cmd_r = '0;
  logic             done_o;
  rsp_t             rsp_o;
  logic             cfg_valid_r = 1'b0;
  logic             cfg_ready_o;
  logic [CAP_W-1:0] cfg_data_r = '0;

  skt_scoreboard sb = new();

  sorted_key_table_core #(
    .DEPTH(TABLE_DEPTH)
  ) u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start      (start),
    .busy       (busy),
    .cmd_i      (cmd_r),
    .done_o     (done_o),
    .rsp_o      (rsp_o),
    .cfg_valid_i(cfg_valid_r),
    .cfg_ready_o(cfg_ready_o),
    .cfg_data_i (cfg_data_r)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    if (rst_ni && done_o) begin
      sb.check_rsp(rsp_o);
    end
  end

  function automatic cmd_t make_cmd(logic [1:0] mode, logic [KEY_W-1:0] key,
                                    logic [POS_W-1:0] pos);
    cmd_t c;
    c.mode = mode_e'(mode);
    c.key_value = key;
    c.position = pos;
    return c;
  endfunction

  // Called at a falling edge; returns at a falling edge, with start still high when no idle gap
  // was drawn, so a back-to-back command keeps it high without a second assignment in the same step.
  task automatic send_cmd(input cmd_t c, input int unsigned idle_pct);
    int unsigned gap;
    start <= 1'b1;
    cmd_r <= c;
    do @(posedge clk_i); while (busy);
    sb.note_cmd(c);
    @(negedge clk_i);
    gap = 0;
    while (gap < MAX_GAP && $urandom_range(99) < idle_pct) gap++;
    if (gap != 0) begin
      start <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
  endtask

  task automatic drain();
    start <= 1'b0;
    @(negedge clk_i);
    while (sb.outstanding() != 0 || busy) @(negedge clk_i);
  endtask

  task automatic write_capacity(input logic [CAP_W-1:0] value);
    drain();
    cfg_valid_r <= 1'b1;
    cfg_data_r <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    sb.set_capacity(value);
    @(negedge clk_i);
    cfg_valid_r <= 1'b0;
  endtask

  function automatic cmd_t random_cmd(int unsigned ins_pct);
    cmd_t        c;
    int unsigned r;
    r = $urandom_range(9);
    if (r == 0) c.key_value = '0;
    else if (r == 1) c.key_value = '1;
    else if (r < 4) c.key_value = 32'h7FFF_FFFE + $urandom_range(3);
    else if (r < 6 && sb.fill > 0) c.key_value = sb.keys[$urandom_range(sb.fill - 1)];
    else c.key_value = $urandom();
    r = $urandom_range(9);
    if (r < 6 && sb.fill > 0) c.position = POS_W'($urandom_range(sb.fill - 1));
    else if (r < 8) c.position = sb.fill[POS_W-1:0];
    else c.position = POS_W'($urandom_range(63));
    r = $urandom_range(99);
    if (r < 3) c.mode = mode_e'(2'd3);
    else if (r < 3 + ins_pct) c.mode = MODE_INSERT;
    else if (r < 3 + ins_pct + (97 - ins_pct) / 2) c.mode = MODE_GET;
    else c.mode = MODE_REMOVE;
    return c;
  endfunction

  initial begin
    int unsigned      caps [8];
    int unsigned      idles [8];
    int unsigned      ins [8];
    int unsigned      p;
    int unsigned      n;
    caps  = '{127, 64, 3, 0, 1, 40, 0, 64};
    idles = '{0, 77, 26, 0, 77, 26, 0, 77};
    ins   = '{80, 45, 50, 50, 50, 55, 50, 40};
    caps[6] = $urandom_range(127);

    repeat (7) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Empty table, unused mode, unsigned ordering, equal keys and index bounds.
    send_cmd(make_cmd(MODE_GET, 32'h0, 6'd0), 0);
    send_cmd(make_cmd(MODE_REMOVE, 32'hFFFF_FFFF, 6'd0), 0);
    send_cmd(make_cmd(2'd3, 32'h1234_5678, 6'd63), 0);
    send_cmd(make_cmd(MODE_INSERT, 32'h8000_0000, 6'd0), 0);
    send_cmd(make_cmd(MODE_INSERT, 32'h0000_0000, 6'd63), 0);
    send_cmd(make_cmd(MODE_INSERT, 32'hFFFF_FFFF, 6'd0), 0);
    send_cmd(make_cmd(MODE_INSERT, 32'h7FFF_FFFF, 6'd0), 0);
    send_cmd(make_cmd(MODE_INSERT, 32'h8000_0000, 6'd0), 0);
    send_cmd(make_cmd(MODE_GET, 32'h0, 6'd0), 0);
    send_cmd(make_cmd(MODE_GET, 32'h0, 6'd4), 0);
    send_cmd(make_cmd(MODE_GET, 32'h0, 6'd5), 0);
    send_cmd(make_cmd(MODE_GET, 32'hFFFF_FFFF, 6'd63), 0);
    send_cmd(make_cmd(MODE_REMOVE, 32'h0, 6'd2), 0);
    send_cmd(make_cmd(MODE_REMOVE, 32'h0, 6'd3), 0);
    send_cmd(make_cmd(2'd3, 32'hFFFF_FFFF, 6'd0), 0);

    // Capacity below the current count, then zero, then above the table depth.
    write_capacity(7'd2);
    send_cmd(make_cmd(MODE_INSERT, 32'h0000_0001, 6'd0), 0);
    send_cmd(make_cmd(MODE_REMOVE, 32'h0, 6'd0), 0);
    send_cmd(make_cmd(MODE_INSERT, 32'h0000_0002, 6'd0), 0);
    send_cmd(make_cmd(MODE_REMOVE, 32'h0, 6'd1), 0);
    send_cmd(make_cmd(MODE_INSERT, 32'h0000_0003, 6'd0), 0);
    write_capacity(7'd0);
    send_cmd(make_cmd(MODE_INSERT, 32'h0000_0004, 6'd0), 0);
    send_cmd(make_cmd(MODE_REMOVE, 32'h0, 6'd0), 0);
    send_cmd(make_cmd(MODE_REMOVE, 32'h0, 6'd0), 0);
    write_capacity(7'd127);
    send_cmd(make_cmd(MODE_INSERT, 32'h0000_5A5A, 6'd0), 0);
    send_cmd(make_cmd(MODE_GET, 32'h0, 6'd0), 0);

    for (p = 0; p < 8; p++) begin
      write_capacity(caps[p][CAP_W-1:0]);
      for (n = 0; n < PHASE_ITEMS; n++) begin
        send_cmd(random_cmd(ins[p]), idles[p]);
      end
    end

    drain();
    repeat (DRAIN_CYCLES) @(negedge clk_i);
    if (sb.errors == 0 && sb.outstanding() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  initial begin
    #5000000;
    $display("CHECK FAILED");
    $finish;
  end

endmodule
